// ----- rtl/tmips_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tmips_pkg;
  localparam int TOP_K_DEF      = 10;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int MAX_DIMS_DEF   = 64;
  localparam int PIDX_W  = 10;
  localparam int DIDX_W  = 6;
  localparam int ELEM_W  = 16;
  localparam int RANK_W  = 6;
  localparam int SCORE_W = 37;
  localparam int NP_W    = 11;
  localparam int ND_W    = 7;
  localparam int CFG_W   = 11;
  localparam int ACC_W   = 48;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_NUM_POINTS = 1'b0;
  localparam logic CFG_NUM_DIMS   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_MAC, ST_DRAIN, ST_OFFER, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;     // reset list and point counter
    logic mac_start; // start a point: zero accumulator and dim counter
    logic mac_run;   // issue one data/query read
    logic offer;     // offer saturated score to list
    logic emit;      // present output rank
  } cmd_t;

  typedef struct packed {
    logic dims_done;   // last read issued for this point
    logic pipe_empty;  // no reads in flight
    logic points_done; // offered last point
    logic last_rank;   // output rank is TOP_K-1
    logic nd_zero;
  } status_t;
endpackage
`default_nettype wire

// ----- rtl/tmips_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tmips_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [9:0]                point_index;
  logic [5:0]                dim_index;
  logic signed [15:0]        elem_value;
  logic                      query_last;
  modport source (output valid, req_type, point_index, dim_index, elem_value, query_last,
                  input ready);
  modport sink (input valid, req_type, point_index, dim_index, elem_value, query_last,
                output ready);
endinterface

interface tmips_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         rank;
  logic [9:0]         result_index;
  logic signed [36:0] result_score;
  logic               result_valid;
  logic               last_result;
  modport source (output valid, rank, result_index, result_score, result_valid, last_result,
                  input ready);
  modport sink (input valid, rank, result_index, result_score, result_valid, last_result,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/tmips_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tmips_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 out_ready,
  input  tmips_pkg::status_t  sts,
  output tmips_pkg::cmd_t     cmd,
  output logic                busy,
  output logic                out_valid
);
  import tmips_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencing: clear, then per point MAC/drain/offer, then emit ranks
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = sts.points_done ? ST_EMIT : ST_MAC;
        cmd.mac_start = 1'b1;
      end
      ST_MAC: begin
        // last read of the point goes out in the cycle that leaves
        if (sts.nd_zero) state_next = ST_DRAIN;
        else begin
          cmd.mac_run = 1'b1;
          if (sts.dims_done) state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) state_next = ST_OFFER;
      end
      ST_OFFER: begin
        cmd.offer = 1'b1;
        cmd.mac_start = 1'b1;
        state_next = sts.points_done ? ST_EMIT : ST_MAC;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (sts.last_rank) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/tmips_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tmips_dp #(
  parameter int TOP_K      = tmips_pkg::TOP_K_DEF,
  parameter int MAX_POINTS = tmips_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = tmips_pkg::MAX_DIMS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               wr_en,
  input  wire                               wr_type,
  input  wire [tmips_pkg::PIDX_W-1:0]       wr_pidx,
  input  wire [tmips_pkg::DIDX_W-1:0]       wr_didx,
  input  wire signed [tmips_pkg::ELEM_W-1:0] wr_val,
  input  wire                               cfg_we,
  input  wire                               cfg_sel,
  input  wire [tmips_pkg::CFG_W-1:0]        cfg_data,
  input  tmips_pkg::cmd_t                   cmd,
  output tmips_pkg::status_t                sts,
  output logic [tmips_pkg::RANK_W-1:0]      o_rank,
  output logic [tmips_pkg::PIDX_W-1:0]      o_index,
  output logic signed [tmips_pkg::SCORE_W-1:0] o_score,
  output logic                              o_valid
);
  import tmips_pkg::*;
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int KW = $clog2(TOP_K + 1);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int DEPTH = MAX_POINTS * MAX_DIMS;

  // stores
  logic signed [ELEM_W-1:0] dmem [DEPTH];
  logic signed [ELEM_W-1:0] qmem [MAX_DIMS];
  logic signed [ELEM_W-1:0] drd, qrd;

  logic [NP_W-1:0] num_points;
  logic [ND_W-1:0] num_dims;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NP_W'(1024);
      num_dims   <= ND_W'(64);
    end else if (cfg_we) begin
      if (cfg_sel == CFG_NUM_POINTS) num_points <= cfg_data[NP_W-1:0];
      else num_dims <= cfg_data[ND_W-1:0];
    end
  end

  // saturated limits
  logic [PCW-1:0] np_lim;
  logic [DCW-1:0] nd_lim;
  always_comb begin
    np_lim = (32'(num_points) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(num_points);
    nd_lim = (32'(num_dims) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(num_dims);
  end

  logic [PCW-1:0] pcnt;
  logic [DCW-1:0] dcnt;
  logic wr_ok;
  assign wr_ok = (32'(wr_pidx) < MAX_POINTS) && (32'(wr_didx) < MAX_DIMS);

  // memory write and read
  logic [PW+DW-1:0] waddr, raddr;
  assign waddr = (PW+DW)'((32'(wr_pidx) * MAX_DIMS) + 32'(wr_didx));
  assign raddr = (PW+DW)'((32'(pcnt[PW-1:0]) * MAX_DIMS) + 32'(dcnt[DW-1:0]));
  always_ff @(posedge clk) begin
    if (wr_en && wr_type == REQ_DATA && wr_ok) dmem[waddr] <= wr_val;
    if (wr_en && wr_type == REQ_QUERY && 32'(wr_didx) < MAX_DIMS)
      qmem[wr_didx[DW-1:0]] <= wr_val;
    drd <= dmem[raddr];
    qrd <= qmem[dcnt[DW-1:0]];
  end

  // read / product / accumulate pipeline
  logic v1, v2;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_run;
      v2 <= v1;
    end
    prod <= drd * qrd;
    if (cmd.mac_start) acc <= '0;
    else if (v2) acc <= acc + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) pcnt <= '0;
    else if (cmd.offer) pcnt <= pcnt + 1'b1;
    if (cmd.mac_start) dcnt <= '0;
    else if (cmd.mac_run) dcnt <= dcnt + 1'b1;
  end

  // saturate score
  logic signed [SCORE_W-1:0] sat;
  always_comb begin
    if (acc > ACC_W'(signed'({1'b0, {(SCORE_W-1){1'b1}}}))) sat = {1'b0, {(SCORE_W-1){1'b1}}};
    else if (acc < -(ACC_W'(64'sd1) <<< (SCORE_W-1))) sat = {1'b1, {(SCORE_W-1){1'b0}}};
    else sat = acc[SCORE_W-1:0];
  end

  // sorted list: insert after all entries with score >= new
  logic signed [SCORE_W-1:0] bs [TOP_K];
  logic [PIDX_W-1:0]         bi [TOP_K];
  logic [TOP_K-1:0]          bv;
  logic [TOP_K-1:0]          ge;
  always_comb begin
    for (int i = 0; i < TOP_K; i++) ge[i] = bv[i] && (bs[i] >= sat);
  end
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) bv <= '0;
    else if (cmd.offer) begin
      for (int i = 0; i < TOP_K; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[i-1 < 0 ? 0 : i-1]) begin
            bv[i] <= 1'b1;
            bs[i] <= sat;
            bi[i] <= PIDX_W'(pcnt);
          end else begin
            // entries below the insertion point move down one place
            bv[i] <= bv[i-1 < 0 ? 0 : i-1];
            bs[i] <= bs[i-1 < 0 ? 0 : i-1];
            bi[i] <= bi[i-1 < 0 ? 0 : i-1];
          end
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < TOP_K-1; i++) begin
        bs[i] <= bs[i+1]; bi[i] <= bi[i+1]; bv[i] <= bv[i+1];
      end
      bv[TOP_K-1] <= 1'b0;
    end
  end

  logic [KW-1:0] rk;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) rk <= '0;
    else if (cmd.emit) rk <= rk + 1'b1;
  end

  assign o_rank  = RANK_W'(rk);
  assign o_valid = bv[0];
  assign o_index = bv[0] ? bi[0] : '0;
  assign o_score = bv[0] ? bs[0] : '0;

  assign sts.dims_done   = (dcnt == nd_lim - 1'b1);
  assign sts.pipe_empty  = !v1 && !v2 && !cmd.mac_run;
  assign sts.points_done = cmd.clear ? (np_lim == '0) : (pcnt + 1'b1 == np_lim);
  assign sts.last_rank   = (32'(rk) == TOP_K - 1);
  assign sts.nd_zero     = (nd_lim == '0);
endmodule
`default_nettype wire

// ----- rtl/topk_max_inner_product_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top-K maximum inner product search.
// in channel: one item per cycle. req_type 0 writes a data element at
// (point_index, dim_index); req_type 1 writes a query element. Both are
// taken only while the block is idle.
// An item with query_last set starts a search: ready drops until all TOP_K
// results have been taken. Each point reads num_dims elements through the
// single data memory port, then drains the pipeline and is inserted into
// the list; after all points come TOP_K output items, rank 0 (highest
// score) first.
// out channel: result items; a stalled receiver holds the current rank
// on the port. Unfilled ranks show result_valid 0 with zero index and score.
// cfg port: cfg_we/cfg_index/cfg_data, index 0 num_points, 1 num_dims.
// Reset (rst, synchronous) restores registers and returns to idle;
// stores keep their contents.
module topk_max_inner_product_search #(
  parameter int TOP_K      = tmips_pkg::TOP_K_DEF,
  parameter int MAX_POINTS = tmips_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = tmips_pkg::MAX_DIMS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  tmips_in_if.sink                     in_ch,
  tmips_out_if.source                  out_ch,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [tmips_pkg::CFG_W-1:0]   cfg_data
);
  import tmips_pkg::*;
  cmd_t    cmd;
  status_t sts;
  logic    busy, acc_in, ov;

  assign in_ch.ready = !busy;
  assign acc_in = in_ch.valid && !busy;

  tmips_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .start(acc_in && in_ch.req_type == REQ_QUERY && in_ch.query_last),
    .out_ready(out_ch.ready), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(ov)
  );

  tmips_dp #(.TOP_K(TOP_K), .MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_dp (
    .clk(clk), .rst(rst),
    .wr_en(acc_in), .wr_type(in_ch.req_type), .wr_pidx(in_ch.point_index),
    .wr_didx(in_ch.dim_index), .wr_val(in_ch.elem_value),
    .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .o_rank(out_ch.rank), .o_index(out_ch.result_index),
    .o_score(out_ch.result_score), .o_valid(out_ch.result_valid)
  );

  assign out_ch.valid       = ov;
  assign out_ch.last_result = sts.last_rank;
endmodule
`default_nettype wire

// ----- rtl/tmips_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tmips_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       last_result,
  input wire [5:0] rank
);
  // no input is taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready while results pending");
  // ranks step by one per taken result
  a_rank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_result) |=> (rank == $past(rank) + 6'd1))
    else $error("rank sequence broken");
  // after the last result the block is idle again
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> (!out_valid && in_ready))
    else $error("not idle after last result");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(rank)))
    else $error("stalled result changed");
endmodule

bind topk_max_inner_product_search tmips_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .last_result(out_ch.last_result), .rank(out_ch.rank)
);
`default_nettype wire
